// ===== sv/frpg_pkg.sv =====
package frpg_pkg;

	typedef struct packed {
		logic [9:0]  target_rate;
		logic [47:0] time_now;
		logic [23:0] pipeline_latency;
		logic [6:0]  drop_rate;
		logic [31:0] drop_sample_id;
		logic [7:0]  backlog_count;
	} sample_t;

	typedef struct packed {
		logic [9:0]  effective_rate;
		logic [3:0]  change_cause;
		logic [31:0] change_score;
	} result_t;

	localparam logic [31:0] US_PER_SEC     = 32'd1000000;
	localparam logic [31:0] SUSTAIN_NUM    = 32'd82000000;
	localparam logic [31:0] CHANGE_GAP_US  = 32'd500000;
	localparam logic [31:0] DECAY_GAP_US   = 32'd250000;
	localparam logic [31:0] CONFIRM_US     = 32'd250000;
	localparam logic [31:0] CLEAN_US       = 32'd5000000;
	localparam logic [31:0] RESTORE_GAP_US = 32'd2000000;
	localparam logic [31:0] SCORE_LIMIT    = 32'd12;
	localparam logic [6:0]  SEVERE_DROP    = 7'd15;
	localparam logic [9:0]  MIN_RATE       = 10'd30;

	localparam logic [3:0] CAUSE_PIPE    = 4'd1;
	localparam logic [3:0] CAUSE_DROP    = 4'd2;
	localparam logic [3:0] CAUSE_BACKLOG = 4'd4;
	localparam logic [3:0] CAUSE_RESTORE = 4'd8;

endpackage

// ===== sv/frpg_sample_if.sv =====
interface frpg_sample_if import frpg_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/frpg_result_if.sv =====
interface frpg_result_if import frpg_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/frame_rate_pressure_governor.sv =====
// channel   dir  payload                                        transfer
// samples   in   target, time, latency, drop, drop id, backlog  valid & ready
// results   out  effective rate, change cause, change score     valid & ready
//
// a result is loaded after the interval division, and after a second division when the rate is
// lowered from a latency average: a shared 32-step restoring divider, one quotient
// bit per cycle, gives the frame interval and then the sustainable rate; a target
// below 30 skips the divider; the next sample is taken once the result is loaded;
// arst_n clears the held and current rates, timers, score and average;
// a finished result waits while the output register still holds an untaken one
module frame_rate_pressure_governor import frpg_pkg::*; #(
	parameter int TIME_WIDTH = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	frpg_sample_if.sink    samples,
	frpg_result_if.source  results
);

	typedef enum logic [2:0] {
		S_IDLE, S_PREP, S_DIV1, S_EVAL, S_DIV2, S_APPLY, S_DONE
	} state_t;

	typedef logic [TIME_WIDTH-1:0] tm_t;

	state_t state_q;

	logic [9:0]  tgt_q;
	tm_t         now_q;
	logic [23:0] lat_q;
	logic [6:0]  drop_q;
	logic [31:0] gen_q;
	logic [7:0]  blog_q;

	logic [9:0]  held_q, cur_q;
	tm_t         lchg_q, ldec_q, clean_q, ovl_q;
	logic [31:0] seen_q;
	logic [25:0] avg_q;
	logic [31:0] score_q, svs_q;
	logic [3:0]  svc_q;

	logic [15:0] interval_q;
	logic        severe_q, usediv_q, low_q;

	// serial divider
	logic [25:0] rem_q;
	logic [31:0] quo_q;
	logic [24:0] den_q;
	logic [4:0]  cnt_q;
	logic [26:0] trial;
	logic        fits;

	logic        out_valid_q;
	result_t     out_q;

	logic [63:0] now_wide;
	tm_t         now_in;

	assign now_wide = {16'b0, samples.data.time_now};
	assign now_in   = now_wide[TIME_WIDTH-1:0];

	assign trial = {1'b0, rem_q[24:0], quo_q[31]} - {2'b0, den_q};
	assign fits  = !trial[26];

	function automatic logic elapsed(tm_t t_now, tm_t t_then, logic [31:0] span);
		tm_t d;
		d = t_now - t_then;
		return (t_now >= t_then) && (d >= TIME_WIDTH'(span));
	endfunction

	function automatic logic [9:0] lower_rate(logic [9:0] cur, logic [9:0] want_in,
		logic [9:0] flr, logic [3:0] step);
		logic [10:0] c, w, f, lim;
		c = {1'b0, cur};
		w = {1'b0, want_in};
		f = {1'b0, flr};
		if (c <= f) return flr;
		if (w >= c || (c - w) < 11'd4)
			w = (c > 11'd4) ? c - 11'd4 : f;
		lim = (c > {7'b0, step}) ? c - {7'b0, step} : f;
		if (w < lim) w = lim;
		if (w < f) w = f;
		w[0] = 1'b0;
		return (w < f) ? flr : w[9:0];
	endfunction

	// evaluation of one sample against the state
	logic        reinit;
	logic [16:0] cap, lat_c;
	logic [24:0] s_val;
	logic [29:0] mix;
	logic [25:0] avg_n;
	logic [30:0] lat100;
	logic [22:0] iv90, iv140, iv80;
	logic        overl, fresh, severe, press, ample, sustained, repeated, chg, rst;
	tm_t         ovl_n, ldec_n, clean_n;
	logic [4:0]  inc;
	logic [32:0] sum;
	logic [31:0] score_n;
	logic [26:0] avg_sum;
	logic [18:0] avg_ceil;
	logic [24:0] avg100;
	logic [9:0]  able, flr, up;
	logic [10:0] up_w;

	assign reinit = (held_q != tgt_q) || (cur_q == 10'd0);

	always_comb begin
		cap    = {interval_q, 1'b0};
		lat_c  = ({7'b0, lat_q} < {8'b0, cap}) ? lat_q[16:0] : cap;
		s_val  = {lat_c, 8'b0};
		mix    = ({avg_q, 3'b0} - {3'b0, avg_q}) + {4'b0, s_val};
		if (lat_q == 24'd0)
			avg_n = avg_q;
		else if (avg_q == 26'd0)
			avg_n = {1'b0, s_val};
		else
			avg_n = mix[28:3];
		lat100 = ({7'b0, lat_q} << 6) + ({7'b0, lat_q} << 5) + ({7'b0, lat_q} << 2);
		iv90   = ({7'b0, interval_q} << 6) + ({7'b0, interval_q} << 4)
			+ ({7'b0, interval_q} << 3) + ({7'b0, interval_q} << 1);
		iv140  = ({7'b0, interval_q} << 7) + ({7'b0, interval_q} << 3)
			+ ({7'b0, interval_q} << 2);
		iv80   = ({7'b0, interval_q} << 6) + ({7'b0, interval_q} << 4);
		overl  = (lat_q != 24'd0) && (lat100 > {8'b0, iv90});
		ovl_n  = overl ? ((ovl_q == '0) ? now_q : ovl_q) : '0;
		fresh  = (drop_q != 7'd0) && (gen_q != 32'd0) && (gen_q != seen_q);
		severe = (blog_q >= 8'd4) || (drop_q >= SEVERE_DROP)
			|| ((lat_q != 24'd0) && (lat100 > {8'b0, iv140}));
		press  = (blog_q != 8'd0) || fresh || overl;
		inc = {4'b0, overl};
		if (blog_q != 8'd0)
			inc = inc + ((blog_q >= 8'd4) ? 5'd8 : ({3'b0, blog_q[1:0]} * 5'd3));
		if (fresh)
			inc = inc + ((drop_q >= SEVERE_DROP) ? 5'd12 : ((drop_q >= 7'd5) ? 5'd8 : 5'd4));
		sum     = {1'b0, score_q} + {28'b0, inc};
		ample   = (lat_q == 24'd0) || (lat100 <= {8'b0, iv80});
		score_n = score_q;
		ldec_n  = ldec_q;
		clean_n = clean_q;
		if (press) begin
			score_n = sum[32] ? '1 : sum[31:0];
			ldec_n  = now_q;
			clean_n = '0;
		end else begin
			if (score_q != 32'd0 && elapsed(now_q, ldec_q, DECAY_GAP_US)) begin
				score_n = score_q - 32'd1;
				ldec_n  = now_q;
			end
			if (ample && drop_q == 7'd0 && clean_q == '0)
				clean_n = now_q;
			else if (!ample || drop_q != 7'd0)
				clean_n = '0;
		end
		sustained = (ovl_n != '0) && elapsed(now_q, ovl_n, CONFIRM_US);
		repeated  = (blog_q != 8'd0) && (score_n >= SCORE_LIMIT);
		chg = elapsed(now_q, lchg_q, CHANGE_GAP_US) && (sustained || fresh || repeated)
			&& (score_n >= SCORE_LIMIT);
		rst = !chg && (cur_q < tgt_q) && (clean_n != '0) && elapsed(now_q, clean_n, CLEAN_US)
			&& elapsed(now_q, lchg_q, RESTORE_GAP_US);
		up_w     = {1'b0, cur_q} + 11'd4;
		up       = (up_w > {1'b0, tgt_q}) ? tgt_q : up_w[9:0];
		avg_sum  = {1'b0, avg_n} + 27'd255;
		avg_ceil = avg_sum[26:8];
		avg100   = ({6'b0, avg_ceil} << 6) + ({6'b0, avg_ceil} << 5) + ({6'b0, avg_ceil} << 2);
		if (!usediv_q)
			able = cur_q;
		else if (quo_q > {22'b0, tgt_q})
			able = tgt_q;
		else
			able = quo_q[9:0];
		if (able > tgt_q) able = tgt_q;
		flr = (tgt_q >= 10'd100) ? 10'd60 : ((tgt_q >= 10'd60) ? 10'd45 : 10'd30);
	end

	assign samples.ready = (state_q == S_IDLE);
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			held_q      <= '0;
			cur_q       <= '0;
			lchg_q      <= '0;
			ldec_q      <= '0;
			clean_q     <= '0;
			ovl_q       <= '0;
			seen_q      <= '0;
			avg_q       <= '0;
			score_q     <= '0;
			svs_q       <= '0;
			svc_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (results.valid && results.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						tgt_q   <= samples.data.target_rate;
						now_q   <= now_in;
						lat_q   <= samples.data.pipeline_latency;
						drop_q  <= samples.data.drop_rate;
						gen_q   <= samples.data.drop_sample_id;
						blog_q  <= samples.data.backlog_count;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					low_q <= (tgt_q < MIN_RATE);
					if (tgt_q < MIN_RATE) begin
						state_q <= S_DONE;
					end else begin
						if (reinit) begin
							held_q  <= tgt_q;
							cur_q   <= tgt_q;
							lchg_q  <= now_q;
							ldec_q  <= now_q;
							clean_q <= '0;
							ovl_q   <= '0;
							seen_q  <= '0;
							avg_q   <= '0;
							score_q <= '0;
							svs_q   <= '0;
							svc_q   <= '0;
						end
						rem_q   <= '0;
						quo_q   <= US_PER_SEC;
						den_q   <= {15'b0, reinit ? tgt_q : cur_q};
						cnt_q   <= '0;
						state_q <= S_DIV1;
					end
				end
				S_DIV1, S_DIV2: begin
					rem_q <= fits ? trial[25:0] : {rem_q[24:0], quo_q[31]};
					quo_q <= {quo_q[30:0], fits};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						if (state_q == S_DIV1)
							state_q <= S_EVAL;
						else
							state_q <= S_APPLY;
					end
					if (state_q == S_DIV1 && cnt_q == 5'd31)
						interval_q <= quo_q[14:0] == 15'd0 && !fits ? 16'd0
							: {quo_q[14:0], fits};
				end
				S_EVAL: begin
					avg_q    <= avg_n;
					seen_q   <= fresh ? gen_q : seen_q;
					severe_q <= severe;
					if (chg) begin
						svs_q   <= score_n;
						svc_q   <= (sustained ? CAUSE_PIPE : 4'd0) | (fresh ? CAUSE_DROP : 4'd0)
							| (repeated ? CAUSE_BACKLOG : 4'd0);
						score_q <= '0;
						lchg_q  <= now_q;
						ldec_q  <= now_q;
						clean_q <= '0;
						ovl_q   <= overl ? now_q : '0;
						if (avg_n != 26'd0) begin
							usediv_q <= 1'b1;
							rem_q    <= '0;
							quo_q    <= SUSTAIN_NUM;
							den_q    <= avg100;
							cnt_q    <= '0;
							state_q  <= S_DIV2;
						end else begin
							usediv_q <= 1'b0;
							state_q  <= S_APPLY;
						end
					end else begin
						ovl_q   <= ovl_n;
						ldec_q  <= ldec_n;
						clean_q <= clean_n;
						if (rst) begin
							cur_q   <= up;
							svs_q   <= score_n;
							svc_q   <= CAUSE_RESTORE;
							lchg_q  <= now_q;
							score_q <= '0;
						end else begin
							score_q <= score_n;
						end
						state_q <= S_DONE;
					end
				end
				S_APPLY: begin
					cur_q   <= lower_rate(cur_q, able, flr, severe_q ? 4'd8 : 4'd4);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q          <= 1'b1;
						out_q.effective_rate <= low_q ? tgt_q : cur_q;
						out_q.change_cause   <= svc_q;
						out_q.change_score   <= svs_q;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rate_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |=> (cur_q <= held_q))
		else $error("lowered rate above target");

	a_score_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && chg) |=> (score_q == 32'd0))
		else $error("score not cleared on rate change");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 && cnt_q == 5'd31) |=> (state_q == S_EVAL))
		else $error("interval division did not finish");

endmodule

// ===== bench/tb_frpg_sample_if.sv =====
`timescale 1ns / 1ps
// the block's interfaces live with the RTL; this file only defines the bench's expected-result type
package tb_frpg_types;
	import frpg_pkg::*;
	typedef struct {
		logic [9:0]  rate;
		logic [3:0]  cause;
		logic [31:0] score;
	} gov_expect_t;
endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import frpg_pkg::*;
	import tb_frpg_types::*;

	logic clk;
	logic arst_n;

	frpg_sample_if samples_if();
	frpg_result_if results_if();

	frame_rate_pressure_governor #(.TIME_WIDTH(48)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if.sink),
		.results(results_if.source)
	);

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int quiet_cycles;
	gov_expect_t rate_queue[$];

	// predictor state
	logic [9:0]  m_held;
	logic [9:0]  m_rate;
	logic [47:0] m_change_t, m_decay_t, m_clean_t, m_over_t;
	logic [31:0] m_seen_id;
	logic [25:0] m_avg;
	logic [31:0] m_score, m_saved_score;
	logic [3:0]  m_saved_cause;
	logic [47:0] clock_us;
	logic [9:0]  cur_target;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit passed(logic [47:0] now, logic [47:0] then, longint unsigned span);
		return now >= then && (now - then) >= span;
	endfunction

	function automatic logic [9:0] floor_for(logic [9:0] t);
		if (t >= 100) return 10'd60;
		if (t >= 60) return 10'd45;
		return 10'd30;
	endfunction

	function automatic int unsigned step_down(int unsigned c, int unsigned w, int unsigned fl,
			int unsigned st);
		int unsigned lim;
		if (c <= fl) return fl;
		if (w >= c || c - w < 4) w = c > 4 ? c - 4 : fl;
		lim = c > st ? c - st : fl;
		if (w < lim) w = lim;
		if (w < fl) w = fl;
		w = w & ~32'd1;
		return w < fl ? fl : w;
	endfunction

	task automatic governor_reinit(logic [9:0] t, logic [47:0] now);
		m_held = t; m_rate = t; m_change_t = now; m_decay_t = now;
		m_clean_t = 0; m_over_t = 0; m_seen_id = 0; m_avg = 0;
		m_score = 0; m_saved_score = 0; m_saved_cause = 0;
	endtask

	task automatic predict_rate(sample_t s);
		gov_expect_t e;
		longint unsigned itv, lat, capv, sv, avgv, able, inc;
		bit over, fresh, severe, press, sust, rep, ample;
		int unsigned cur;
		if (s.target_rate < MIN_RATE) begin
			e.rate = s.target_rate; e.cause = m_saved_cause; e.score = m_saved_score;
			rate_queue.push_back(e);
			return;
		end
		if (m_held != s.target_rate || m_rate == 0) governor_reinit(s.target_rate, s.time_now);
		cur = m_rate;
		itv = cur != 0 ? 64'd1000000 / cur : 64'd33333;
		lat = s.pipeline_latency;
		if (lat != 0) begin
			capv = itv * 2;
			sv = (lat < capv ? lat : capv) << 8;
			avgv = m_avg == 0 ? sv : (64'(m_avg) * 7 + sv) / 8;
			m_avg = avgv[25:0];
		end
		over = lat != 0 && lat * 100 > itv * 90;
		if (over) begin
			if (m_over_t == 0) m_over_t = s.time_now;
		end else m_over_t = 0;
		fresh = s.drop_rate != 0 && s.drop_sample_id != 0 && s.drop_sample_id != m_seen_id;
		if (fresh) m_seen_id = s.drop_sample_id;
		severe = s.backlog_count >= 4 || s.drop_rate >= SEVERE_DROP ||
			(lat != 0 && lat * 100 > itv * 140);
		press = s.backlog_count != 0 || fresh || over;
		if (press) begin
			inc = over ? 1 : 0;
			if (s.backlog_count != 0) inc += s.backlog_count >= 4 ? 8 : s.backlog_count * 3;
			if (fresh) inc += s.drop_rate >= SEVERE_DROP ? 12 : (s.drop_rate >= 5 ? 8 : 4);
			m_score = (64'(m_score) + inc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m_score + inc;
			m_decay_t = s.time_now;
			m_clean_t = 0;
		end else begin
			if (m_score != 0 && passed(s.time_now, m_decay_t, 250000)) begin
				m_score--;
				m_decay_t = s.time_now;
			end
			ample = lat == 0 || lat * 100 <= itv * 80;
			if (ample && s.drop_rate == 0 && m_clean_t == 0) m_clean_t = s.time_now;
			else if (!ample || s.drop_rate != 0) m_clean_t = 0;
		end
		sust = m_over_t != 0 && passed(s.time_now, m_over_t, 250000);
		rep = s.backlog_count != 0 && m_score >= SCORE_LIMIT;
		if (passed(s.time_now, m_change_t, 500000) && (sust || fresh || rep) &&
				m_score >= SCORE_LIMIT) begin
			able = cur;
			if (m_avg != 0) begin
				avgv = (64'(m_avg) + 255) >> 8;
				if (avgv != 0) able = 64'd82000000 / (avgv * 100);
			end
			if (able > s.target_rate) able = s.target_rate;
			m_rate = 10'(step_down(cur, able, floor_for(s.target_rate), severe ? 8 : 4));
			m_saved_score = m_score;
			m_saved_cause = (sust ? CAUSE_PIPE : 4'd0) | (fresh ? CAUSE_DROP : 4'd0) |
				(rep ? CAUSE_BACKLOG : 4'd0);
			m_score = 0;
			m_change_t = s.time_now; m_decay_t = s.time_now; m_clean_t = 0;
			m_over_t = over ? s.time_now : 48'd0;
		end else if (m_rate < s.target_rate && m_clean_t != 0 &&
				passed(s.time_now, m_clean_t, 5000000) &&
				passed(s.time_now, m_change_t, 2000000)) begin
			m_rate = (m_rate + 4 > s.target_rate) ? s.target_rate : m_rate + 10'd4;
			m_saved_score = m_score;
			m_saved_cause = CAUSE_RESTORE;
			m_change_t = s.time_now;
			m_score = 0;
		end
		e.rate = m_rate; e.cause = m_saved_cause; e.score = m_saved_score;
		rate_queue.push_back(e);
	endtask

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	task automatic send_sample(sample_t s);
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		samples_if.valid <= 1'b1;
		samples_if.data <= s;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		predict_rate(s);
		samples_if.valid <= 1'b0;
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		gov_expect_t e;
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				if (rate_queue.size() == 0) begin
					report_mismatch("pending results", 0, 1);
				end else begin
					e = rate_queue.pop_front();
					if (results_if.data.effective_rate !== e.rate)
						report_mismatch("effective_rate", results_if.data.effective_rate, e.rate);
					if (results_if.data.change_cause !== e.cause)
						report_mismatch("change_cause", results_if.data.change_cause, e.cause);
					if (results_if.data.change_score !== e.score)
						report_mismatch("change_score", results_if.data.change_score, e.score);
				end
			end
			results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic sample_t make_sample(logic [9:0] t, logic [23:0] lat, logic [6:0] drop,
			logic [31:0] id, logic [7:0] bl);
		sample_t s;
		s.target_rate = t; s.time_now = clock_us; s.pipeline_latency = lat;
		s.drop_rate = drop; s.drop_sample_id = id; s.backlog_count = bl;
		return s;
	endfunction

	task automatic drain_results();
		while (rate_queue.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		clock_us = 0;
		send_sample(make_sample(10'd0, 24'd0, 7'd0, 32'd0, 8'd0));
		send_sample(make_sample(10'd29, 24'hFFFFFF, 7'd127, 32'hFFFFFFFF, 8'hFF));
		send_sample(make_sample(10'd1000, 24'd0, 7'd0, 32'd0, 8'd0));
		send_sample(make_sample(10'd1023, 24'hFFFFFF, 7'd100, 32'd5, 8'd255));
		clock_us = 48'd600000;
		send_sample(make_sample(10'd1023, 24'hFFFFFF, 7'd127, 32'd6, 8'd3));
		send_sample(make_sample(10'd30, 24'd40000, 7'd0, 32'd0, 8'd0));
		for (int i = 0; i < 8; i++) begin
			clock_us += 48'd300000;
			send_sample(make_sample(10'd60, 24'd30000, 7'd20, 32'(i + 1), 8'd1));
		end
		// clean stretch for restore
		for (int i = 0; i < 6; i++) begin
			clock_us += 48'd1500000;
			send_sample(make_sample(10'd60, 24'd1000, 7'd0, 32'd0, 8'd0));
		end
		clock_us = 48'd100;
		send_sample(make_sample(10'd60, 24'd1000, 7'd0, 32'd0, 8'd0));
		clock_us = 48'hFFFF_FFFF_FFFF;
		send_sample(make_sample(10'd100, 24'd1, 7'd1, 32'd1, 8'd2));
		drain_results();
	endtask

	task automatic test_random(int count);
		int burst;
		logic [9:0] t;
		sample_t s;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 3) cur_target = 10'($urandom_range(30, 1000));
			if ($urandom_range(99) < 4) begin
				s = sample_t'({$urandom, $urandom, $urandom, $urandom});
			end else begin
				t = ($urandom_range(99) < 5) ? 10'($urandom_range(29)) : cur_target;
				if ($urandom_range(99) < 2) clock_us -= 48'($urandom_range(300000));
				else clock_us += 48'($urandom_range(($urandom_range(9) == 0) ? 3000000 : 400000));
				s = make_sample(t,
					($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(60000)),
					($urandom_range(2) == 0) ? 7'd0 : 7'($urandom_range(30)),
					($urandom_range(2) == 0) ? 32'd0 : 32'($urandom_range(50)),
					($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(6)));
			end
			send_sample(s);
		end
	endtask

	task automatic test_pause_for_drain();
		send_sample(make_sample(cur_target, 24'd20000, 7'd3, 32'd77, 8'd1));
		drain_results();
		send_sample(make_sample(cur_target, 24'd0, 7'd0, 32'd0, 8'd0));
	endtask

	initial begin
		samples_if.valid = 1'b0;
		samples_if.data = '0;
		results_if.ready = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 24;
		recv_idle_pct = 56;
		cur_target = 10'd120;
		governor_reinit(10'd0, 48'd0);
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(330);
		test_pause_for_drain();
		send_idle_pct = 56;
		recv_idle_pct = 24;
		test_random(330);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(330);
		drain_results();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && rate_queue.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
